FILE: hdl/roi_pkg.sv
// Package: shared types and constants of the ray versus oriented-box test.
package roi_pkg;

  localparam int unsigned AxisN = 3;
  localparam int unsigned DistW = 32;
  localparam int unsigned TagW = 16;
  localparam int unsigned NumW = 64;

  // Register indexes.
  localparam logic [2:0] RegOrgX = 3'd0;
  localparam logic [2:0] RegOrgY = 3'd1;
  localparam logic [2:0] RegOrgZ = 3'd2;
  localparam logic [2:0] RegDirX = 3'd3;
  localparam logic [2:0] RegDirY = 3'd4;
  localparam logic [2:0] RegDirZ = 3'd5;
  localparam logic [2:0] RegThr = 3'd6;

  // One slab job handed from the front end to the divider back end.
  typedef struct packed {
    logic              par;   // axis counts as parallel
    logic              pmiss; // parallel axis misses (|e| > h)
    logic signed [NumW-1:0] num_n; // (e + h) * 2^16
    logic signed [NumW-1:0] num_f; // (e - h) * 2^16
    logic signed [NumW-1:0] den;   // c
  } slab_t;

  typedef struct packed {
    slab_t [AxisN-1:0] slab;
    logic [TagW-1:0]   tag;
  } job_t;

endpackage

FILE: hdl/roi_front.sv
// Front end: projects the box offset and ray direction onto each box axis.
module roi_front #(
  parameter int unsigned POS_WIDTH = 21,
  parameter int unsigned DIR_WIDTH = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3*POS_WIDTH-1:0]        center_i,
  input  logic [3*DIR_WIDTH-1:0]        axis_u_i,
  input  logic [3*DIR_WIDTH-1:0]        axis_v_i,
  input  logic [3*DIR_WIDTH-1:0]        axis_w_i,
  input  logic [3*(POS_WIDTH-1)-1:0]    half_i,
  input  logic [roi_pkg::TagW-1:0]      tag_i,
  input  logic signed [POS_WIDTH-1:0]   org_i [3],
  input  logic signed [DIR_WIDTH-1:0]   dir_i [3],
  input  logic [7:0]                    thr_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output roi_pkg::job_t                 job_o
);
  import roi_pkg::*;

  localparam int unsigned HalfW = POS_WIDTH - 1;
  localparam int unsigned RelW = POS_WIDTH + 1;
  localparam int unsigned ProdW = RelW + DIR_WIDTH;

  // Stage 1: products of axis components with offset and direction.
  logic                     s1_v_q;
  logic signed [ProdW-1:0]  pe_q [3][3];
  logic signed [2*DIR_WIDTH-1:0] pc_q [3][3];
  logic [HalfW-1:0]         h1_q [3];
  logic [TagW-1:0]          tag1_q;
  // Stage 2: the finished job.
  logic                     s2_v_q;
  job_t                     job_q;

  logic adv1, adv2;
  assign adv2 = !s2_v_q || job_ready_i;
  assign adv1 = !s1_v_q || adv2;
  assign in_ready_o = adv1;
  assign job_valid_o = s2_v_q;
  assign job_o = job_q;

  logic signed [DIR_WIDTH-1:0] ax [3][3];
  logic signed [RelW-1:0]      rel [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[0][k] = $signed(axis_u_i[k*DIR_WIDTH +: DIR_WIDTH]);
      ax[1][k] = $signed(axis_v_i[k*DIR_WIDTH +: DIR_WIDTH]);
      ax[2][k] = $signed(axis_w_i[k*DIR_WIDTH +: DIR_WIDTH]);
      rel[k] = RelW'($signed(center_i[k*POS_WIDTH +: POS_WIDTH])) - RelW'(org_i[k]);
    end
  end

  // Hold the valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= in_valid_i;
      if (adv2) s2_v_q <= s1_v_q;
    end
  end

  // Multiply.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pe_q[i][k] <= ProdW'(ax[i][k]) * ProdW'(rel[k]);
          pc_q[i][k] <= (2*DIR_WIDTH)'(ax[i][k]) * (2*DIR_WIDTH)'(dir_i[k]);
        end
        h1_q[i] <= half_i[i*HalfW +: HalfW];
      end
      tag1_q <= tag_i;
    end
  end

  // Sum the products and form the slab numerators.
  job_t jd;
  always_comb begin
    logic signed [NumW-1:0] e, c, h, ae, thr;
    jd = '0;
    thr = NumW'({thr_i, 16'd0});
    for (int i = 0; i < 3; i++) begin
      e = NumW'(pe_q[i][0]) + NumW'(pe_q[i][1]) + NumW'(pe_q[i][2]);
      c = NumW'(pc_q[i][0]) + NumW'(pc_q[i][1]) + NumW'(pc_q[i][2]);
      h = NumW'({h1_q[i], 16'd0});
      ae = e[NumW-1] ? -e : e;
      jd.slab[i].par = ((c[NumW-1] ? -c : c) <= thr);
      jd.slab[i].pmiss = (ae > h);
      jd.slab[i].num_n = (e + h) <<< 16;
      jd.slab[i].num_f = (e - h) <<< 16;
      jd.slab[i].den = c;
    end
    jd.tag = tag1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv2) job_q <= jd;
  end

endmodule

FILE: hdl/roi_fifo.sv
// Short queue between the front end and the back end.
module roi_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);
  logic [Width-1:0] mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

FILE: hdl/roi_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module roi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic signed [roi_pkg::NumW-1:0] num_i,
  input  logic signed [roi_pkg::NumW-1:0] den_i,
  output logic signed [roi_pkg::NumW-1:0] quo_o
);
  import roi_pkg::*;

  localparam int unsigned Nw = NumW;

  logic [Nw-1:0]   rem_q [Nw+1];
  logic [Nw-1:0]   quo_q [Nw+1];
  logic [Nw-1:0]   den_q [Nw+1];
  logic            neg_q [Nw+1];

  logic [Nw-1:0] an, ad;
  assign an = num_i[Nw-1] ? Nw'(-num_i) : Nw'(num_i);
  assign ad = den_i[Nw-1] ? Nw'(-den_i) : Nw'(den_i);

  // Advance the restoring division one bit per stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= an;
      den_q[0] <= ad;
      neg_q[0] <= num_i[Nw-1] ^ den_i[Nw-1];
      for (int s = 0; s < Nw; s++) begin
        logic [Nw:0] r;
        r = {rem_q[s], quo_q[s][Nw-1]};
        if (r >= {1'b0, den_q[s]}) begin
          rem_q[s+1] <= Nw'(r - {1'b0, den_q[s]});
          quo_q[s+1] <= {quo_q[s][Nw-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= Nw'(r);
          quo_q[s+1] <= {quo_q[s][Nw-2:0], 1'b0};
        end
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quo_o = neg_q[Nw] ? -$signed(quo_q[Nw]) : $signed(quo_q[Nw]);

  logic unused;
  assign unused = rst_ni;
endmodule

FILE: hdl/roi_back.sv
// Back end: slab divisions, interval narrowing and the result register.
module roi_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  roi_pkg::job_t        job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [roi_pkg::DistW+roi_pkg::TagW:0] out_o
);
  import roi_pkg::*;

  localparam int unsigned Lat = NumW + 1;

  logic en;
  logic out_v_q;
  logic [DistW+TagW:0] out_q;
  logic [Lat-1:0] v_q;
  job_t job_q [Lat];
  logic signed [NumW-1:0] qn [3], qf [3];

  // The whole pipe moves when the output slot can take its last item.
  assign en = !(out_v_q && !out_ready_i && v_q[Lat-1]);
  assign job_ready_o = en;
  assign out_valid_o = out_v_q;
  assign out_o = out_q;

  for (genvar i = 0; i < 3; i++) begin : g_div
    roi_div u_dn (.clk_i, .rst_ni, .en_i(en), .num_i(job_i.slab[i].num_n),
                  .den_i(job_i.slab[i].den), .quo_o(qn[i]));
    roi_div u_df (.clk_i, .rst_ni, .en_i(en), .num_i(job_i.slab[i].num_f),
                  .den_i(job_i.slab[i].den), .quo_o(qf[i]));
  end

  // Carry job flags alongside the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[Lat-2:0], job_valid_i};
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      job_q[0] <= job_i;
      for (int s = 1; s < Lat; s++) job_q[s] <= job_q[s-1];
    end
  end

  // Narrow the interval over the three axes.
  logic [DistW+TagW:0] res;
  always_comb begin
    logic hn, hf, miss, bnd;
    logic signed [NumW-1:0] tn, tf, n, f, t;
    logic [DistW-1:0] distance;
    hn = 1'b0; hf = 1'b0; miss = 1'b0; tn = '0; tf = '0;
    for (int i = 0; i < 3; i++) begin
      n = qn[i]; f = qf[i];
      if (f < n) begin
        n = qf[i]; f = qn[i];
      end
      if (!miss) begin
        if (!job_q[Lat-1].slab[i].par) begin
          if (!hn || n > tn) begin tn = n; hn = 1'b1; end
          if (!hf || f < tf) begin tf = f; hf = 1'b1; end
          if (tn > tf || tf < 0) miss = 1'b1;
        end else if (job_q[Lat-1].slab[i].pmiss) begin
          miss = 1'b1;
        end
      end
    end
    if (hn && tn > 0) begin t = tn; bnd = 1'b1; end
    else begin t = tf; bnd = hf; end
    if (miss) distance = '0;
    else if (!bnd || t > NumW'(64'hFFFF_FFFF)) distance = '1;
    else distance = DistW'(t);
    res = {job_q[Lat-1].tag, distance, !miss};
  end

  // Hold the result until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en && v_q[Lat-1]) out_v_q <= 1'b1;
    else if (out_ready_i) out_v_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (en && v_q[Lat-1]) out_q <= res;
  end
endmodule

FILE: hdl/ray_obb_intersect.sv
// Top level: ray versus oriented-box slab test with APB ray registers.
//  channel | dir | group                     | content
//  boxes   | in  | s_axis_*                  | centre, axes, half sides, tag
//  results | out | m_axis_*                  | hit, distance, tag
//  config  | in  | psel/penable/pwrite/paddr | ray origin, direction, threshold
// One box is accepted per cycle while the front is ready. A box passes the front
// registers (products, then the finished job), the queue, 65 divider stages (an input
// stage, then one quotient bit per stage) and the result register before it is offered.
// Reset clears all valid flags and loads the default ray (+z direction).
// A stalled result halts the back end once another result waits behind it; the queue then fills and the front stalls.
module ray_obb_intersect #(
  parameter int unsigned POS_WIDTH = 21,
  parameter int unsigned DIR_WIDTH = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // box_center, axis_u, axis_v, axis_w, half_sides, box_tag (low to high)
  input  logic [((6*POS_WIDTH-3+9*DIR_WIDTH+16)+7)/8*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit, distance, result_tag (low to high), zero filled
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import roi_pkg::*;

  localparam int unsigned CW = 3*POS_WIDTH;
  localparam int unsigned AW = 3*DIR_WIDTH;
  localparam int unsigned HW = 3*(POS_WIDTH-1);

  logic signed [POS_WIDTH-1:0] org_q [3];
  logic signed [DIR_WIDTH-1:0] dir_q [3];
  logic [7:0] thr_q;
  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  // Write ray registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
      dir_q[0] <= '0; dir_q[1] <= '0;
      dir_q[2] <= DIR_WIDTH'(65536);
      thr_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        RegOrgX: org_q[0] <= pwdata[POS_WIDTH-1:0];
        RegOrgY: org_q[1] <= pwdata[POS_WIDTH-1:0];
        RegOrgZ: org_q[2] <= pwdata[POS_WIDTH-1:0];
        RegDirX: dir_q[0] <= pwdata[DIR_WIDTH-1:0];
        RegDirY: dir_q[1] <= pwdata[DIR_WIDTH-1:0];
        RegDirZ: dir_q[2] <= pwdata[DIR_WIDTH-1:0];
        RegThr:  thr_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (ridx)
      RegOrgX: prdata = 32'(unsigned'(org_q[0]));
      RegOrgY: prdata = 32'(unsigned'(org_q[1]));
      RegOrgZ: prdata = 32'(unsigned'(org_q[2]));
      RegDirX: prdata = 32'(unsigned'(dir_q[0]));
      RegDirY: prdata = 32'(unsigned'(dir_q[1]));
      RegDirZ: prdata = 32'(unsigned'(dir_q[2]));
      RegThr:  prdata = 32'(thr_q);
      default: prdata = '0;
    endcase
  end

  logic f_v, f_r, b_v, b_r;
  job_t f_job, b_job;

  roi_front #(.POS_WIDTH(POS_WIDTH), .DIR_WIDTH(DIR_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .center_i(s_axis_tdata[CW-1:0]),
    .axis_u_i(s_axis_tdata[CW +: AW]),
    .axis_v_i(s_axis_tdata[CW+AW +: AW]),
    .axis_w_i(s_axis_tdata[CW+2*AW +: AW]),
    .half_i(s_axis_tdata[CW+3*AW +: HW]),
    .tag_i(s_axis_tdata[CW+3*AW+HW +: TagW]),
    .org_i(org_q), .dir_i(dir_q), .thr_i(thr_q),
    .job_valid_o(f_v), .job_ready_i(f_r), .job_o(f_job)
  );

  roi_fifo #(.Width($bits(job_t))) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_v), .wr_ready_o(f_r), .wr_data_i(f_job),
    .rd_valid_o(b_v), .rd_ready_i(b_r), .rd_data_o(b_job)
  );

  logic [DistW+TagW:0] res;
  roi_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_v), .job_ready_o(b_r), .job_i(b_job),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tdata = {7'd0, res};

  logic unused;
  assign unused = ^{paddr[1:0], pwdata[31:8]};
endmodule
